// ===== rtl/lppr_pkg.sv =====
// shared types and constants for the length prefixed packet receiver
package lppr_pkg;

   // largest accepted length byte, checksum byte included
   localparam int MaxPacketLen = 16;
   // width of the byte counters, wide enough to hold MaxPacketLen
   localparam int CountW = $clog2(MaxPacketLen + 1);

   // request kinds
   localparam logic [1:0] ReqStart = 2'd0;
   localparam logic [1:0] ReqByte  = 2'd1;
   localparam logic [1:0] ReqTick  = 2'd2;

   // result kinds
   localparam logic [1:0] KindTx     = 2'd0;
   localparam logic [1:0] KindStored = 2'd1;
   localparam logic [1:0] KindDone   = 2'd2;

   // register indexes
   localparam logic [1:0] RegTimeout = 2'd0;
   localparam logic [1:0] RegOkCode  = 2'd1;
   localparam logic [1:0] RegFail    = 2'd2;

   // register reset values
   localparam logic [7:0] TimeoutReset = 8'h64;
   localparam logic [7:0] OkCodeReset  = 8'h00;
   localparam logic [7:0] FailReset    = 8'hFF;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_type_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [3:0] out_index;
      logic       success;
      logic       last_of_run;
   } rsp_type;

endpackage

// ===== rtl/length_prefixed_packet_receiver_unit.sv =====
// length prefixed packet receiver: request decode, packet state and result queue
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  request | req_valid, req_ready, req_payload  | in
//  result  | rsp_valid, rsp_ready, rsp_payload  | out
//  config  | csr_we, csr_index, csr_wdata       | in
//
// a request is taken when req_valid and req_ready are high; its zero to three
// results enter a four entry queue at that edge and leave one per cycle while
// rsp_ready is high, from the next cycle on. req_ready needs room for three
// results, so it is low while the queue holds more than one result.
// synchronous reset clears the packet state and the queue and loads the
// register defaults (timeout 100, ok code 0, fail code 255).
module length_prefixed_packet_receiver_unit
   import lppr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_payload,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_DATA
   } phase_type;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // configuration registers
   logic [7:0] timeout_ticks_ff;
   logic [7:0] ok_reply_code_ff;
   logic [7:0] fail_reply_code_ff;

   // packet state
   phase_type         phase_ff, phase_in;
   logic [CountW-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]        running_sum_ff, running_sum_in;
   logic [7:0]        tick_count_ff, tick_count_in;
   logic [CountW-1:0] write_index_ff, write_index_in;

   // result queue
   rsp_type          queue_mem [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff, count_in;

   // results of the current request
   rsp_type    res0, res1, res2;
   logic [1:0] res_n;

   logic accept;
   logic pop;

   assign req_ready   = (count_ff <= QCntW'(QDepth - 3));
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = (count_ff != '0);
   assign pop         = rsp_valid && rsp_ready;
   assign rsp_payload = queue_mem[rd_ptr_ff];

   // request decode and next packet state
   always_comb begin
      logic [7:0]        sum_add;
      logic [7:0]        tick_inc;
      logic [CountW-1:0] left_dec;
      logic [CountW-1:0] index_inc;
      logic              ok;

      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      tick_count_in  = tick_count_ff;
      write_index_in = write_index_ff;
      res0  = '0;
      res1  = '0;
      res2  = '0;
      res_n = 2'd0;

      sum_add   = running_sum_ff + req_payload.data_byte;
      tick_inc  = (tick_count_ff != 8'hFF) ? tick_count_ff + 8'd1 : tick_count_ff;
      left_dec  = (bytes_left_ff != '0) ? bytes_left_ff - CountW'(1) : bytes_left_ff;
      index_inc = write_index_ff + CountW'(1);
      ok        = (sum_add == 8'h00);

      case (req_payload.req_type)
         ReqStart: begin
            if (phase_ff == PH_IDLE) begin
               res0.out_kind  = KindTx;
               res0.out_byte  = req_payload.data_byte;
               res_n          = 2'd1;
               phase_in       = PH_LEN;
               bytes_left_in  = '0;
               running_sum_in = '0;
               tick_count_in  = '0;
               write_index_in = '0;
            end
         end
         ReqByte: begin
            if (phase_ff == PH_LEN) begin
               tick_count_in = '0;
               if (req_payload.data_byte < 8'd2 ||
                   req_payload.data_byte > 8'(MaxPacketLen)) begin
                  // bad length: fail code then finished
                  res0.out_kind   = KindTx;
                  res0.out_byte   = fail_reply_code_ff;
                  res1.out_kind   = KindDone;
                  res1.out_index  = write_index_ff[3:0];
                  res_n           = 2'd2;
                  phase_in        = PH_IDLE;
                  bytes_left_in   = '0;
                  running_sum_in  = '0;
               end else begin
                  running_sum_in = req_payload.data_byte;
                  bytes_left_in  = CountW'(req_payload.data_byte - 8'd1);
                  phase_in       = PH_DATA;
               end
            end else if (phase_ff == PH_DATA) begin
               tick_count_in   = '0;
               running_sum_in  = sum_add;
               res0.out_kind   = KindStored;
               res0.out_byte   = req_payload.data_byte;
               res0.out_index  = write_index_ff[3:0];
               res_n           = 2'd1;
               write_index_in  = index_inc;
               bytes_left_in   = left_dec;
               if (left_dec == '0) begin
                  // last byte: reply code then finished
                  res1.out_kind  = KindTx;
                  res1.out_byte  = ok ? ok_reply_code_ff : fail_reply_code_ff;
                  res2.out_kind  = KindDone;
                  res2.out_index = index_inc[3:0];
                  res2.success   = ok;
                  res_n          = 2'd3;
                  phase_in       = PH_IDLE;
                  bytes_left_in  = '0;
                  running_sum_in = '0;
               end
            end
         end
         ReqTick: begin
            if (phase_ff != PH_IDLE) begin
               tick_count_in = tick_inc;
               if (tick_inc >= timeout_ticks_ff) begin
                  // timeout: fail code then finished
                  res0.out_kind  = KindTx;
                  res0.out_byte  = fail_reply_code_ff;
                  res1.out_kind  = KindDone;
                  res1.out_index = write_index_ff[3:0];
                  res_n          = 2'd2;
                  phase_in       = PH_IDLE;
                  bytes_left_in  = '0;
                  running_sum_in = '0;
                  tick_count_in  = '0;
               end
            end
         end
         default: begin
            res_n = 2'd0;
         end
      endcase

      // mark the final result of this request
      case (res_n)
         2'd1:    res0.last_of_run = 1'b1;
         2'd2:    res1.last_of_run = 1'b1;
         2'd3:    res2.last_of_run = 1'b1;
         default: res_n = 2'd0;
      endcase
   end

   // queue occupancy
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_in + QCntW'(res_n);
      end
      if (pop) begin
         count_in = count_in - QCntW'(1);
      end
   end

   // state, configuration and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff   <= TimeoutReset;
         ok_reply_code_ff   <= OkCodeReset;
         fail_reply_code_ff <= FailReset;
         phase_ff           <= PH_IDLE;
         bytes_left_ff      <= '0;
         running_sum_ff     <= '0;
         tick_count_ff      <= '0;
         write_index_ff     <= '0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         count_ff           <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegTimeout: timeout_ticks_ff   <= csr_wdata;
               RegOkCode:  ok_reply_code_ff   <= csr_wdata;
               RegFail:    fail_reply_code_ff <= csr_wdata;
               default:    timeout_ticks_ff   <= timeout_ticks_ff;
            endcase
         end
         if (accept) begin
            phase_ff       <= phase_in;
            bytes_left_ff  <= bytes_left_in;
            running_sum_ff <= running_sum_in;
            tick_count_ff  <= tick_count_in;
            write_index_ff <= write_index_in;
            wr_ptr_ff      <= wr_ptr_ff + QPtrW'(res_n);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
         count_ff <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         if (res_n >= 2'd1) begin
            queue_mem[wr_ptr_ff] <= res0;
         end
         if (res_n >= 2'd2) begin
            queue_mem[wr_ptr_ff + QPtrW'(1)] <= res1;
         end
         if (res_n == 2'd3) begin
            queue_mem[wr_ptr_ff + QPtrW'(2)] <= res2;
         end
      end
   end

endmodule
